// ----- hw/rtl/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfp_pkg
// shared types and codes for the csv field parser and its channels
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // result kinds
  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_FEND = 2'd1;
  localparam kind_t KIND_LEND = 2'd2;

  // input actions
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t CFG_DELIM = 4'd0;
  localparam cfg_idx_t CFG_QUOTE = 4'd1;

  // register reset values
  localparam byte_t DELIM_RST = 8'd44;
  localparam byte_t QUOTE_RST = 8'd34;

  typedef struct packed {
    kind_t kind;
    byte_t data_byte;
    logic  malformed;
    logic  last;
  } result_t;

endpackage

// ----- hw/rtl/cfp_in_if.sv -----
// ----------------------------------------------------------------------------
// cfp_in_if
// character channel into the parser: one character or an end of line
// ----------------------------------------------------------------------------
interface cfp_in_if;
  logic           valid;
  logic           ready;
  logic           action;
  cfp_pkg::byte_t char_byte;

  modport source (output valid, output action, output char_byte, input ready);
  modport sink   (input valid, input action, input char_byte, output ready);
endinterface

// ----- hw/rtl/cfp_out_if.sv -----
// ----------------------------------------------------------------------------
// cfp_out_if
// result channel out of the parser: field bytes, field ends and line ends
// ----------------------------------------------------------------------------
interface cfp_out_if;
  logic           valid;
  logic           ready;
  cfp_pkg::kind_t kind;
  cfp_pkg::byte_t data_byte;
  logic           malformed;
  logic           last;

  modport source (output valid, output kind, output data_byte, output malformed,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input malformed,
                  input last, output ready);
endinterface

// ----- hw/rtl/cfp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// cfp_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface cfp_cfg_if;
  logic              valid;
  logic              ready;
  cfp_pkg::cfg_idx_t index;
  cfp_pkg::byte_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/csv_field_parser.sv -----
// ----------------------------------------------------------------------------
// csv_field_parser
// splits a line of text into fields, honouring quoted fields and doubled
// quotes, and flags malformed lines on the line end transaction
// ----------------------------------------------------------------------------
//
//   channel  dir  transaction                         payload
//   -------  ---  ----------------------------------  --------------------------
//   in_ch    in   one character or an end of line     action, char_byte
//   out_ch   out  field byte, field end or line end   kind, data_byte,
//                                                     malformed, last
//   cfg_ch   in   register write (always ready)       index, data
//
// an in_ch transaction is parsed in the cycle it is taken and its results
// enter a small result queue at that edge; the queue head drives out_ch next cycle
// a character gives at most one result, an end of line up to two; characters
// flow at one per cycle, and each two-result end of line leaves one extra queued
// in_ch is ready while the queue has room for two results, so a stall on out_ch
// or a run of ends of line holds in_ch off; reset: field start, comma, quote, empty
//
module csv_field_parser #(
  parameter int unsigned QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH  // at least 2
) (
  input  logic      clk,
  input  logic      rst_n,
  cfp_in_if.sink    in_ch,
  cfp_out_if.source out_ch,
  cfp_cfg_if.sink   cfg_ch
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] ACCEPT_MAX = CNT_W'(QUEUE_DEPTH - 2);

  // parse modes
  localparam logic [2:0] MODE_START   = 3'd0;  // at the start of a field
  localparam logic [2:0] MODE_PLAIN   = 3'd1;  // inside an unquoted field
  localparam logic [2:0] MODE_OPENED  = 3'd2;  // opening quote just taken
  localparam logic [2:0] MODE_INQUOTE = 3'd3;  // inside a quoted field
  localparam logic [2:0] MODE_QSEEN   = 3'd4;  // quote seen inside quotes
  localparam logic [2:0] MODE_ERROR   = 3'd5;  // discarding to end of line

  // configuration registers
  cfp_pkg::byte_t delim_r;
  cfp_pkg::byte_t quote_r;

  // parser state
  logic [2:0] mode_r;
  logic [2:0] mode_nxt;

  // result queue
  cfp_pkg::result_t q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [PTR_W-1:0] wr_ptr_2;

  logic             in_acc;
  logic             out_acc;
  logic             is_quote;
  logic             is_delim;
  logic [1:0]       n_res;
  cfp_pkg::result_t res0;
  cfp_pkg::result_t res1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_ch.ready  = (count_r <= ACCEPT_MAX);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_acc      = out_ch.valid & out_ch.ready;

  // ---------------------------------------------------------------------------
  // configuration writes; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= cfp_pkg::DELIM_RST;
      quote_r <= cfp_pkg::QUOTE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        cfp_pkg::CFG_DELIM: delim_r <= cfg_ch.data;
        cfp_pkg::CFG_QUOTE: quote_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // parse step: quote takes priority when delimiter and quote coincide
  // ---------------------------------------------------------------------------
  assign is_quote = (in_ch.char_byte == quote_r);
  assign is_delim = (in_ch.char_byte == delim_r) && !is_quote;

  always_comb begin
    mode_nxt = mode_r;
    n_res    = 2'd0;
    res0     = '{kind: cfp_pkg::KIND_DATA, data_byte: in_ch.char_byte,
                 malformed: 1'b0, last: 1'b1};
    res1     = '{kind: cfp_pkg::KIND_LEND, data_byte: '0,
                 malformed: 1'b0, last: 1'b1};

    if (in_ch.action == cfp_pkg::ACT_EOL) begin
      mode_nxt = MODE_START;
      if (mode_r == MODE_INQUOTE || mode_r == MODE_ERROR) begin
        // unclosed quote after field bytes, or earlier error: line end only, flagged
        n_res = 2'd1;
        res0  = '{kind: cfp_pkg::KIND_LEND, data_byte: '0,
                  malformed: 1'b1, last: 1'b1};
      end else begin
        // close the open (possibly empty) field, then end the line
        n_res = 2'd2;
        res0  = '{kind: cfp_pkg::KIND_FEND, data_byte: '0,
                  malformed: 1'b0, last: 1'b0};
      end
    end else begin
      unique case (mode_r) inside
        MODE_START: begin
          if (is_quote) begin
            mode_nxt = MODE_OPENED;
          end else if (is_delim) begin
            n_res = 2'd1;
            res0  = '{kind: cfp_pkg::KIND_FEND, data_byte: '0,
                      malformed: 1'b0, last: 1'b1};
          end else begin
            n_res    = 2'd1;
            mode_nxt = MODE_PLAIN;
          end
        end
        MODE_PLAIN: begin
          n_res = 2'd1;
          if (is_delim) begin
            res0     = '{kind: cfp_pkg::KIND_FEND, data_byte: '0,
                         malformed: 1'b0, last: 1'b1};
            mode_nxt = MODE_START;
          end
        end
        MODE_OPENED, MODE_INQUOTE: begin
          if (is_quote) begin
            mode_nxt = MODE_QSEEN;
          end else begin
            n_res    = 2'd1;
            mode_nxt = MODE_INQUOTE;
          end
        end
        MODE_QSEEN: begin
          if (is_quote) begin
            // doubled quote: one literal quote byte
            n_res    = 2'd1;
            mode_nxt = MODE_INQUOTE;
          end else if (is_delim) begin
            n_res    = 2'd1;
            res0     = '{kind: cfp_pkg::KIND_FEND, data_byte: '0,
                         malformed: 1'b0, last: 1'b1};
            mode_nxt = MODE_START;
          end else begin
            mode_nxt = MODE_ERROR;
          end
        end
        MODE_ERROR: ;
        default: mode_nxt = MODE_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue: up to two writes, one read per cycle
  // ---------------------------------------------------------------------------
  assign wr_ptr_2 = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (in_acc && n_res == 2'd1) begin
      wr_ptr_nxt = wr_ptr_2;
    end else if (in_acc && n_res == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_2);
    end
    rd_ptr_nxt = out_acc ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(in_acc ? n_res : 2'd0) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      q_r[wr_ptr_2] <= res1;
    end
  end

  // queue head drives the result channel
  assign out_ch.valid     = (count_r != '0);
  assign out_ch.kind      = q_r[rd_ptr_r].kind;
  assign out_ch.data_byte = q_r[rd_ptr_r].data_byte;
  assign out_ch.malformed = q_r[rd_ptr_r].malformed;
  assign out_ch.last      = q_r[rd_ptr_r].last;

endmodule

// ----- hw/rtl/cfp_checker.sv -----
// ----------------------------------------------------------------------------
// cfp_checker
// port-level checks on the csv field parser, bound to its top level
// ----------------------------------------------------------------------------
module cfp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_action,
  input logic           out_valid,
  input logic           out_ready,
  input cfp_pkg::kind_t out_kind,
  input cfp_pkg::byte_t out_data_byte,
  input logic           out_malformed,
  input logic           out_last
);

  // an end of line always leaves a result waiting on the next cycle
  a_eol_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == cfp_pkg::ACT_EOL |=> out_valid)
    else $error("end of line left no result");

  // malformed only rides on a line end
  a_malformed_on_lend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != cfp_pkg::KIND_LEND |-> !out_malformed)
    else $error("malformed set on a non line end result");

  // markers carry a zero byte
  a_marker_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != cfp_pkg::KIND_DATA |-> out_data_byte == '0)
    else $error("marker result with a non-zero byte");

  // a line end is always the final result of its transaction
  a_lend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cfp_pkg::KIND_LEND |-> out_last)
    else $error("line end without last");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

endmodule

bind csv_field_parser cfp_checker u_cfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_action     (in_ch.action),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.kind),
  .out_data_byte (out_ch.data_byte),
  .out_malformed (out_ch.malformed),
  .out_last      (out_ch.last)
);
